// ----- rtl/ile_pkg.sv -----
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and constants for the indexed list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ile_pkg;

   localparam int DATA_W   = 32;
   localparam int POS_W    = 16;
   localparam int OP_W     = 3;
   localparam int ST_W     = 2;
   // cells per first-level group of the read gather
   localparam int SEG_SIZE = 16;

   typedef enum logic [OP_W-1:0] {
      OP_READ     = 3'd0,
      OP_INS_HEAD = 3'd1,
      OP_INS_TAIL = 3'd2,
      OP_INS_POS  = 3'd3,
      OP_DELETE   = 3'd4
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_EXEC   = 2'd1,
      S_FINISH = 2'd2
   } state_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic              ins;
      logic              del;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] data;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ----- rtl/ile_if.sv -----
// ----------------------------------------------------------------------------
// ile_if
// Command and response channel interfaces of the indexed list engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface ile_req_if;
   logic                                valid;
   logic                                ready;
   logic [ile_pkg::OP_W-1:0]            opcode;
   logic signed [ile_pkg::POS_W-1:0]    position;
   logic signed [ile_pkg::DATA_W-1:0]   value;

   modport source (output valid, output opcode, output position, output value,
                   input ready);
   modport sink   (input valid, input opcode, input position, input value,
                   output ready);
endinterface

interface ile_rsp_if #(
   parameter int CAPACITY = 256
);
   localparam int LEN_W = $clog2(CAPACITY + 1);

   logic                                valid;
   logic                                ready;
   logic [ile_pkg::ST_W-1:0]            status;
   logic signed [ile_pkg::DATA_W-1:0]   read_value;
   logic [LEN_W-1:0]                    list_length;

   modport source (output valid, output status, output read_value,
                   output list_length, input ready);
   modport sink   (input valid, input status, input read_value,
                   input list_length, output ready);
endinterface

`default_nettype wire

// ----- rtl/indexed_list_engine.sv -----
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of signed 32-bit values with read, insert and delete by position.
// ----------------------------------------------------------------------------
// Each transaction passes the idle state, in which it is accepted, the execute
// state, in which the whole row of cells shifts in parallel (and the read gather
// captures its first level), and the finish state, in which the response
// register is loaded. The response register is separate, so the next command is
// taken while an earlier response still waits; the finish state stretches while
// that response is held. A new command is not taken until the current one has
// left the finish state, as set by the control sequence around the cell row.
// Contents of cells at or beyond the list length are undefined; the length
// resets to zero.
`default_nettype none

module indexed_list_engine #(
   parameter int CAPACITY = 256
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ile_req_if.sink     req_ch,
   ile_rsp_if.source   rsp_ch
);

   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam int DW    = ile_pkg::DATA_W;
   localparam int PW    = ile_pkg::POS_W;

   ile_pkg::state_type   state_ff, state_in;
   ile_pkg::op_type      op_ff;
   logic [PW-1:0]        pos_ff;
   logic [DW-1:0]        val_ff;
   logic [LEN_W-1:0]     count_ff, count_in;

   ile_pkg::status_type  st_ff, st_in;
   logic                 is_read_ff, is_read_in;
   logic                 miss_ff, miss_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   ile_pkg::status_type  rsp_status_ff;
   logic [DW-1:0]        rsp_data_ff, rsp_data_in;
   logic [LEN_W-1:0]     rsp_len_ff;

   logic                 accept;
   logic                 load_rsp;
   logic                 full;
   logic [PW-1:0]        cnt_pos;
   logic                 bad_idx;
   ile_pkg::cell_cmd_type cmd;
   logic [DW-1:0]        cell_val [CAPACITY];
   logic [DW-1:0]        gather_data;

   assign accept   = req_ch.valid && req_ch.ready;
   assign full     = (count_ff == LEN_W'(CAPACITY));
   assign cnt_pos  = PW'(count_ff);
   assign bad_idx  = pos_ff[PW-1] || (pos_ff >= cnt_pos);

   // ---------------- control ----------------
   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      load_rsp     = 1'b0;
      cmd          = '0;
      cmd.pos      = pos_ff;
      cmd.data     = val_ff;
      st_in        = st_ff;
      is_read_in   = is_read_ff;
      miss_in      = miss_ff;
      count_in     = count_ff;

      case (state_ff)
         ile_pkg::S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               state_in = ile_pkg::S_EXEC;
            end
         end
         ile_pkg::S_EXEC: begin
            st_in      = ile_pkg::ST_DONE;
            is_read_in = 1'b0;
            miss_in    = 1'b0;
            case (op_ff)
               ile_pkg::OP_READ: begin
                  is_read_in = 1'b1;
                  if (bad_idx) begin
                     miss_in = 1'b1;
                     st_in   = ile_pkg::ST_RANGE;
                  end
               end
               ile_pkg::OP_INS_HEAD: begin
                  cmd.pos = '0;
                  if (full) st_in = ile_pkg::ST_FULL;
                  else cmd.ins = 1'b1;
               end
               ile_pkg::OP_INS_TAIL: begin
                  cmd.pos = cnt_pos;
                  if (full) st_in = ile_pkg::ST_FULL;
                  else cmd.ins = 1'b1;
               end
               ile_pkg::OP_INS_POS: begin
                  // range check comes before the full check
                  if (pos_ff[PW-1] || (pos_ff > cnt_pos)) st_in = ile_pkg::ST_RANGE;
                  else if (full) st_in = ile_pkg::ST_FULL;
                  else cmd.ins = 1'b1;
               end
               ile_pkg::OP_DELETE: begin
                  if (bad_idx) st_in = ile_pkg::ST_RANGE;
                  else cmd.del = 1'b1;
               end
               default: begin
               end
            endcase
            if (cmd.ins) count_in = count_ff + LEN_W'(1);
            else if (cmd.del) count_in = count_ff - LEN_W'(1);
            state_in = ile_pkg::S_FINISH;
         end
         ile_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_rsp = 1'b1;
               state_in = ile_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ile_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ile_pkg::S_IDLE;
         count_ff   <= '0;
         st_ff      <= ile_pkg::ST_DONE;
         is_read_ff <= 1'b0;
         miss_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         st_ff      <= st_in;
         is_read_ff <= is_read_in;
         miss_ff    <= miss_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= ile_pkg::op_type'(req_ch.opcode);
         pos_ff <= req_ch.position;
         val_ff <= req_ch.value;
      end
   end

   // ---------------- cell row ----------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DW-1:0] left_v;
      logic [DW-1:0] right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = cell_val[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = cell_val[i];
      end else begin : g_mid_r
         assign right_v = cell_val[i+1];
      end
      ile_cell #(
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (cell_val[i])
      );
   end

   ile_gather #(
      .CAPACITY (CAPACITY)
   ) u_gather (
      .clock (clock),
      .load  (state_ff == ile_pkg::S_EXEC),
      .pos   (pos_ff),
      .cells (cell_val),
      .data  (gather_data)
   );

   // ---------------- response register ----------------
   always_comb begin
      if (!is_read_ff) rsp_data_in = '0;
      else if (miss_ff) rsp_data_in = '1;
      else rsp_data_in = gather_data;
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= st_ff;
         rsp_data_ff   <= rsp_data_in;
         rsp_len_ff    <= count_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.read_value  = rsp_data_ff;
   assign rsp_ch.list_length = rsp_len_ff;

   // ---------------- assertions ----------------
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LEN_W'(CAPACITY))
      else $error("list length exceeds capacity");

   a_len_only_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ile_pkg::S_EXEC) |=> $stable(count_ff))
      else $error("list length changed outside execute cycle");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ile_pkg::S_FINISH))
      else $error("response raised without a finished command");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ile_pkg::ST_FULL))
         |-> (rsp_len_ff == LEN_W'(CAPACITY)))
      else $error("full status reported below capacity");

endmodule

`default_nettype wire

// ----- rtl/ile_cell.sv -----
// ----------------------------------------------------------------------------
// ile_cell
// One list slot. Holds, loads the new value, or takes a neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                         clock,
   input  wire ile_pkg::cell_cmd_type        cmd,
   input  wire logic [ile_pkg::DATA_W-1:0]   left_value,
   input  wire logic [ile_pkg::DATA_W-1:0]   right_value,
   output logic [ile_pkg::DATA_W-1:0]        value
);

   localparam logic [ile_pkg::POS_W-1:0] MY_POS = ile_pkg::POS_W'(INDEX);

   logic [ile_pkg::DATA_W-1:0] value_ff;
   logic [ile_pkg::DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (cmd.ins) begin
         if (MY_POS == cmd.pos) begin
            value_in = cmd.data;
         end else if (MY_POS > cmd.pos) begin
            value_in = left_value;
         end
      end else if (cmd.del && (MY_POS >= cmd.pos)) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// ----- rtl/ile_gather.sv -----
// ----------------------------------------------------------------------------
// ile_gather
// Read path: picks one cell by position in two levels, first level registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_gather #(
   parameter int CAPACITY = 256
) (
   input  wire logic                         clock,
   input  wire logic                         load,
   input  wire logic [ile_pkg::POS_W-1:0]    pos,
   input  wire logic [ile_pkg::DATA_W-1:0]   cells [CAPACITY],
   output logic [ile_pkg::DATA_W-1:0]        data
);

   localparam int SEG  = ile_pkg::SEG_SIZE;
   localparam int NSEG = (CAPACITY + SEG - 1) / SEG;

   logic [ile_pkg::DATA_W-1:0] part_ff [NSEG];
   logic [ile_pkg::DATA_W-1:0] part_in [NSEG];

   // at most one cell matches, so an OR of the masked cells is the select
   always_comb begin
      for (int s = 0; s < NSEG; s++) begin
         part_in[s] = '0;
         for (int j = 0; j < SEG; j++) begin
            if ((s * SEG + j) < CAPACITY) begin
               if (pos == ile_pkg::POS_W'(s * SEG + j)) begin
                  part_in[s] = part_in[s] | cells[s * SEG + j];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int s = 0; s < NSEG; s++) begin
            part_ff[s] <= part_in[s];
         end
      end
   end

   always_comb begin
      data = '0;
      for (int s = 0; s < NSEG; s++) begin
         data = data | part_ff[s];
      end
   end

endmodule

`default_nettype wire

// ----- bench/tb_indexed_list_engine.sv -----
// ----------------------------------------------------------------------------
// tb_indexed_list_engine
// Self-checking bench for the indexed list engine. A directed table hits the
// empty list, range edges, extreme values and spare opcodes. Random traffic
// follows: mixed bursts, a fill to capacity, then a drain to empty. Every
// response is compared with a table entry or a queue-based model of the list.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_indexed_list_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY      = 256;
   localparam int LEN_W         = $clog2(CAPACITY + 1);
   localparam int OP_W          = ile_pkg::OP_W;
   localparam int POS_W         = ile_pkg::POS_W;
   localparam int DATA_W        = ile_pkg::DATA_W;
   localparam int ST_W          = ile_pkg::ST_W;
   localparam int RESET_CYCLES  = 11;
   localparam int RANDOM_ITEMS  = 650;
   localparam int NUM_DIRECTED  = 25;
   localparam int TOTAL_ITEMS   = NUM_DIRECTED + RANDOM_ITEMS;
   localparam int FILL_START    = 60;
   localparam int FULL_EXTRA    = 10;
   localparam int EMPTY_EXTRA   = 6;
   localparam int MODE_RUN      = 20;
   localparam int NOISE_PCT     = 5;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 12;

   // opcodes the block leaves unused
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   localparam logic signed [POS_W-1:0]  POS_MIN    = 16'sh8000;
   localparam logic signed [POS_W-1:0]  POS_MAX    = 16'sh7FFF;
   localparam logic signed [DATA_W-1:0] VAL_MIN    = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX    = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

   typedef struct packed {
      logic [OP_W-1:0]            opcode;
      logic signed [POS_W-1:0]    position;
      logic signed [DATA_W-1:0]   value;
   } list_cmd_type;

   typedef struct packed {
      logic [ST_W-1:0]            status;
      logic signed [DATA_W-1:0]   read_value;
      logic [LEN_W-1:0]           list_length;
   } list_rsp_type;

   typedef struct packed {
      list_cmd_type  cmd;
      logic          typed;
      list_rsp_type  rsp;
   } dir_row_type;

   typedef enum {MODE_MIX, MODE_GROW, MODE_SHRINK} traffic_mode_type;
   typedef enum {PH_WARM, PH_FILL, PH_DRAIN, PH_TAIL} fill_phase_type;

   localparam dir_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{'{ile_pkg::OP_READ, 16'sd0, 32'sd0}, 1'b1, '{ile_pkg::ST_RANGE, MISS_VALUE, 9'd0}},
      '{'{ile_pkg::OP_DELETE, 16'sd0, 32'sd0}, 1'b1, '{ile_pkg::ST_RANGE, 32'sd0, 9'd0}},
      '{'{ile_pkg::OP_READ, POS_MIN, 32'sd0}, 1'b1, '{ile_pkg::ST_RANGE, MISS_VALUE, 9'd0}},
      '{'{ile_pkg::OP_INS_POS, 16'sd1, 32'sd1}, 1'b1, '{ile_pkg::ST_RANGE, 32'sd0, 9'd0}},
      '{'{ile_pkg::OP_INS_POS, POS_MIN, 32'sd2}, 1'b1, '{ile_pkg::ST_RANGE, 32'sd0, 9'd0}},
      '{'{ile_pkg::OP_INS_POS, 16'sd0, VAL_MAX}, 1'b1, '{ile_pkg::ST_DONE, 32'sd0, 9'd1}},
      '{'{ile_pkg::OP_INS_HEAD, POS_MAX, VAL_MIN}, 1'b1, '{ile_pkg::ST_DONE, 32'sd0, 9'd2}},
      '{'{ile_pkg::OP_INS_TAIL, -16'sd1, MISS_VALUE}, 1'b1, '{ile_pkg::ST_DONE, 32'sd0, 9'd3}},
      '{'{ile_pkg::OP_READ, 16'sd0, 32'sd0}, 1'b1, '{ile_pkg::ST_DONE, VAL_MIN, 9'd3}},
      '{'{ile_pkg::OP_READ, 16'sd1, VAL_MIN}, 1'b1, '{ile_pkg::ST_DONE, VAL_MAX, 9'd3}},
      // stored all-ones reads back with a done status
      '{'{ile_pkg::OP_READ, 16'sd2, 32'sd0}, 1'b0, '0},
      '{'{ile_pkg::OP_READ, 16'sd3, 32'sd0}, 1'b1, '{ile_pkg::ST_RANGE, MISS_VALUE, 9'd3}},
      '{'{ile_pkg::OP_READ, POS_MAX, 32'sd0}, 1'b1, '{ile_pkg::ST_RANGE, MISS_VALUE, 9'd3}},
      // insert at the length appends
      '{'{ile_pkg::OP_INS_POS, 16'sd3, 32'sd5}, 1'b0, '0},
      '{'{ile_pkg::OP_INS_POS, 16'sd1, 32'sh1234_5678}, 1'b0, '0},
      '{'{ile_pkg::OP_INS_POS, 16'sd6, 32'sd9}, 1'b1, '{ile_pkg::ST_RANGE, 32'sd0, 9'd5}},
      '{'{ile_pkg::OP_READ, 16'sd1, 32'sd0}, 1'b0, '0},
      '{'{OP_SPARE_LO, 16'sd0, 32'sh5555_5555}, 1'b1, '{ile_pkg::ST_DONE, 32'sd0, 9'd5}},
      '{'{OP_SPARE_HI, -16'sd1, MISS_VALUE}, 1'b1, '{ile_pkg::ST_DONE, 32'sd0, 9'd5}},
      '{'{ile_pkg::OP_DELETE, 16'sd5, 32'sd0}, 1'b1, '{ile_pkg::ST_RANGE, 32'sd0, 9'd5}},
      '{'{ile_pkg::OP_DELETE, -16'sd1, 32'sd0}, 1'b1, '{ile_pkg::ST_RANGE, 32'sd0, 9'd5}},
      '{'{ile_pkg::OP_DELETE, 16'sd4, 32'sd0}, 1'b0, '0},
      '{'{ile_pkg::OP_DELETE, 16'sd0, 32'sd0}, 1'b0, '0},
      '{'{ile_pkg::OP_READ, 16'sd0, 32'sd0}, 1'b0, '0},
      '{'{ile_pkg::OP_READ, 16'sd2, 32'sd0}, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   ile_req_if                          req_ch();
   ile_rsp_if #(.CAPACITY(CAPACITY))   rsp_ch();

   indexed_list_engine #(.CAPACITY(CAPACITY)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic signed [DATA_W-1:0] list_cells[$];
   list_rsp_type             pending_list_rsps[$];
   int                       fail_count   = 0;
   int                       sent_items   = 0;
   int                       req_idle_pct = 0;
   int                       rsp_idle_pct = 0;
   int                       stall_cycles = 0;

   function automatic logic [ST_W-1:0] insert_cell(int p, logic signed [DATA_W-1:0] v);
      if (list_cells.size() >= CAPACITY) begin
         return ile_pkg::ST_FULL;
      end
      list_cells.insert(p, v);
      return ile_pkg::ST_DONE;
   endfunction

   // updates the list model and returns the response the block owes
   function automatic list_rsp_type apply_list_op(list_cmd_type c);
      list_rsp_type r;
      int           len;
      int           p;
      len          = list_cells.size();
      p            = int'(c.position);
      r.status     = ile_pkg::ST_DONE;
      r.read_value = '0;
      case (c.opcode)
         ile_pkg::OP_READ: begin
            if (p < 0 || p >= len) begin
               r.status     = ile_pkg::ST_RANGE;
               r.read_value = MISS_VALUE;
            end else begin
               r.read_value = list_cells[p];
            end
         end
         ile_pkg::OP_INS_HEAD: r.status = insert_cell(0, c.value);
         ile_pkg::OP_INS_TAIL: r.status = insert_cell(len, c.value);
         ile_pkg::OP_INS_POS: begin
            // range check wins over the full check
            if (p < 0 || p > len) r.status = ile_pkg::ST_RANGE;
            else                  r.status = insert_cell(p, c.value);
         end
         ile_pkg::OP_DELETE: begin
            if (p < 0 || p >= len) r.status = ile_pkg::ST_RANGE;
            else                   list_cells.delete(p);
         end
         default: ;
      endcase
      r.list_length = LEN_W'(list_cells.size());
      return r;
   endfunction

   function automatic list_cmd_type pick_list_cmd(traffic_mode_type mode);
      list_cmd_type c;
      int           len;
      int           r;
      int           w_read;
      int           w_head;
      int           w_tail;
      int           w_ins;
      len        = list_cells.size();
      c.value    = DATA_W'($urandom);
      c.position = POS_W'($urandom);
      case (mode)
         MODE_GROW:   begin w_read = 5;  w_head = 30; w_tail = 30; w_ins = 32; end
         MODE_SHRINK: begin w_read = 6;  w_head = 1;  w_tail = 1;  w_ins = 2;  end
         default:     begin w_read = 30; w_head = 15; w_tail = 15; w_ins = 15; end
      endcase
      if ($urandom_range(0, 99) < NOISE_PCT) begin
         // any opcode, positions around and beyond the range edges
         c.opcode = OP_W'($urandom_range(0, OP_SPARE_HI));
         case ($urandom_range(0, 3))
            1: c.position = POS_W'(len);
            2: c.position = POS_W'(len + 1);
            3: c.position = POS_W'(-1 - int'($urandom_range(0, 7)));
            default: ;
         endcase
         return c;
      end
      r = $urandom_range(0, 99);
      if (r < w_read) begin
         c.opcode   = ile_pkg::OP_READ;
         c.position = (len > 0) ? POS_W'($urandom_range(0, len - 1)) : '0;
      end else if (r < w_read + w_head) begin
         c.opcode = ile_pkg::OP_INS_HEAD;
      end else if (r < w_read + w_head + w_tail) begin
         c.opcode = ile_pkg::OP_INS_TAIL;
      end else if (r < w_read + w_head + w_tail + w_ins) begin
         c.opcode   = ile_pkg::OP_INS_POS;
         c.position = POS_W'($urandom_range(0, len));
      end else begin
         c.opcode   = ile_pkg::OP_DELETE;
         c.position = (len > 0) ? POS_W'($urandom_range(0, len - 1)) : '0;
      end
      return c;
   endfunction

   // entered and left at a rising edge; valid stays up across back-to-back commands
   task automatic send_command(list_cmd_type c, logic typed, list_rsp_type typed_rsp);
      list_rsp_type predicted;
      if (sent_items < TOTAL_ITEMS / 3) begin
         req_idle_pct = 28;
         rsp_idle_pct = 77;
      end else if (sent_items < 2 * TOTAL_ITEMS / 3) begin
         req_idle_pct = 77;
         rsp_idle_pct = 28;
      end else begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.opcode   <= c.opcode;
      req_ch.position <= c.position;
      req_ch.value    <= c.value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = apply_list_op(c);
      pending_list_rsps.push_back(typed ? typed_rsp : predicted);
      sent_items++;
   endtask

   // response side: random backpressure and field-by-field compare
   initial begin
      list_rsp_type want;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_list_rsps.size() == 0) begin
               $display("%0t: unexpected transaction, status %0d read %0d length %0d",
                        $time, rsp_ch.status, rsp_ch.read_value, rsp_ch.list_length);
               fail_count++;
            end else begin
               want = pending_list_rsps.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_ch.status);
                  fail_count++;
               end
               if (rsp_ch.read_value !== want.read_value) begin
                  $display("%0t: read_value mismatch, expected %0d, actual %0d",
                           $time, want.read_value, rsp_ch.read_value);
                  fail_count++;
               end
               if (rsp_ch.list_length !== want.list_length) begin
                  $display("%0t: list_length mismatch, expected %0d, actual %0d",
                           $time, want.list_length, rsp_ch.list_length);
                  fail_count++;
               end
            end
         end
         rsp_ch.ready <= !reset && ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // watchdog: too long without any transaction on either side
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      traffic_mode_type mode;
      fill_phase_type   phase;
      int               n;
      int               extra;
      req_ch.valid    = 1'b0;
      req_ch.opcode   = ile_pkg::OP_READ;
      req_ch.position = '0;
      req_ch.value    = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_command(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rsp);
      end

      // mixed bursts, then fill to capacity and push past it, drain, more bursts
      mode  = MODE_MIX;
      phase = PH_WARM;
      n     = 0;
      extra = 0;
      while (n < RANDOM_ITEMS || phase != PH_TAIL) begin
         case (phase)
            PH_FILL: begin
               mode = MODE_GROW;
               if (list_cells.size() == CAPACITY) extra++;
               if (extra == FULL_EXTRA) begin
                  phase = PH_DRAIN;
                  extra = 0;
               end
            end
            PH_DRAIN: begin
               mode = MODE_SHRINK;
               if (list_cells.size() == 0) extra++;
               if (extra == EMPTY_EXTRA) phase = PH_TAIL;
            end
            default: begin
               if (n % MODE_RUN == 0) begin
                  case ($urandom_range(0, 9))
                     8:       mode = MODE_GROW;
                     9:       mode = MODE_SHRINK;
                     default: mode = MODE_MIX;
                  endcase
               end
               if (phase == PH_WARM && n == FILL_START) phase = PH_FILL;
            end
         endcase
         send_command(pick_list_cmd(mode), 1'b0, '0);
         n++;
      end
      req_ch.valid <= 1'b0;

      while (pending_list_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/ile_pkg.sv
rtl/ile_if.sv
rtl/ile_cell.sv
rtl/ile_gather.sv
rtl/indexed_list_engine.sv
bench/tb_indexed_list_engine.sv
